>>> rtl/prr_pkg.sv
// Package for the permutation rank / unrank block.
// Beat types, opcode codes, widths and the factorial function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

  localparam int DIGIT_W          = 4;
  localparam int RANK_W           = 19;
  localparam int PERM_W           = 36;
  localparam int FACT_W           = 32;   // 12! fits
  localparam int MAX_ELEMS        = 12;
  localparam int MASK_W           = 16;   // one bit per 4-bit digit code
  localparam int NUM_ELEMENTS_DEF = 9;

  typedef enum logic [0:0] {
    OP_RANK   = 1'b0,
    OP_UNRANK = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [PERM_W-1:0]   perm_in;
    logic [RANK_W-1:0]   rank_in;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]   rank_out;
    logic [PERM_W-1:0]   perm_out;
    logic                error;
  } out_item_t;

  // Work carried from cell to cell
  typedef struct packed {
    opcode_t              opcode;
    logic                 err;
    logic [MAX_ELEMS-1:0] used;    // digits already taken
    logic [PERM_W-1:0]    digits;  // remaining input digits, next one in low nibble
    logic [RANK_W-1:0]    num;     // rank accumulator or remainder
    logic [PERM_W-1:0]    perm;    // permutation being built
  } stage_t;

  function automatic logic [FACT_W-1:0] fact(input int k);
    logic [FACT_W-1:0] f;
    f = 1;
    for (int i = 2; i <= k; i++) begin
      f = f * FACT_W'(i);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

>>> rtl/prr_cell.sv
// One position of the rank / unrank chain, with its stage register.
// Depends on prr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prr_cell #(
  parameter int NUM_ELEMENTS = prr_pkg::NUM_ELEMENTS_DEF,
  parameter int POS          = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire prr_pkg::stage_t up_stage,
  output logic                 down_valid,
  input  wire logic            down_ready,
  output prr_pkg::stage_t      down_stage
);

  localparam int KMAX = NUM_ELEMENTS - 1 - POS;
  localparam logic [prr_pkg::FACT_W-1:0] FACT = prr_pkg::fact(KMAX);
  localparam logic [prr_pkg::RANK_W-1:0] FACT_LO = FACT[prr_pkg::RANK_W-1:0];
  localparam logic [prr_pkg::FACT_W-1:0] RANK_LIM =
    prr_pkg::FACT_W'(64'd1 << prr_pkg::RANK_W);
  localparam logic [prr_pkg::DIGIT_W:0] N_L = (prr_pkg::DIGIT_W+1)'(NUM_ELEMENTS);
  localparam bit PLACE = (prr_pkg::DIGIT_W * POS) < prr_pkg::PERM_W;
  localparam int PLACE_LSB = PLACE ? prr_pkg::DIGIT_W * POS : 0;
  localparam int PROD_W = prr_pkg::RANK_W + prr_pkg::DIGIT_W;

  logic                            valid_r;
  prr_pkg::stage_t                 stage_r;
  prr_pkg::stage_t                 stage_nxt;

  logic [prr_pkg::DIGIT_W-1:0]     digit;
  logic [prr_pkg::MASK_W-1:0]      used_ext;
  logic [prr_pkg::MASK_W-1:0]      below_d;
  logic [prr_pkg::DIGIT_W-1:0]     smaller;
  logic [PROD_W-1:0]               rank_prod;
  logic                            bad;
  logic [prr_pkg::FACT_W-1:0]      thr;
  logic [prr_pkg::DIGIT_W-1:0]     dsel;
  logic [prr_pkg::RANK_W-1:0]      sub_val;
  logic [prr_pkg::MASK_W-1:0]      below_j;
  logic [prr_pkg::DIGIT_W:0]       cnt;
  logic [prr_pkg::DIGIT_W-1:0]     pick;
  logic [prr_pkg::MASK_W-1:0]      used_rank;
  logic [prr_pkg::MASK_W-1:0]      used_unrank;
  logic [prr_pkg::PERM_W-1:0]      perm_unrank;

  // Ranking: count free digits below this one, scale by the factorial
  always_comb begin
    digit     = up_stage.digits[prr_pkg::DIGIT_W-1:0];
    used_ext  = prr_pkg::MASK_W'(up_stage.used);
    below_d   = (prr_pkg::MASK_W'(1) << digit) - prr_pkg::MASK_W'(1);
    smaller   = prr_pkg::DIGIT_W'($countones(~used_ext & below_d));
    rank_prod = PROD_W'(smaller) * PROD_W'(FACT_LO);
    bad       = ({1'b0, digit} >= N_L) || used_ext[digit];
    used_rank = used_ext | (prr_pkg::MASK_W'(1) << digit);
  end

  // Unranking: digit index = remainder / factorial, via constant thresholds
  always_comb begin
    dsel    = '0;
    sub_val = '0;
    thr     = '0;
    for (int k = 1; k <= KMAX; k++) begin
      thr = prr_pkg::FACT_W'(k) * FACT;
      if ((thr < RANK_LIM) && (prr_pkg::FACT_W'(up_stage.num) >= thr)) begin
        dsel    = prr_pkg::DIGIT_W'(k);
        sub_val = thr[prr_pkg::RANK_W-1:0];
      end
    end
  end

  // Pick the dsel-th free digit; free counts rise strictly, so one match
  always_comb begin
    pick    = '0;
    below_j = '0;
    cnt     = '0;
    for (int j = 0; j < NUM_ELEMENTS; j++) begin
      below_j = (prr_pkg::MASK_W'(1) << j) - prr_pkg::MASK_W'(1);
      cnt     = (prr_pkg::DIGIT_W+1)'($countones(~used_ext & below_j));
      if (!used_ext[j] && (cnt == {1'b0, dsel})) begin
        pick = prr_pkg::DIGIT_W'(j);
      end
    end
    used_unrank = used_ext | (prr_pkg::MASK_W'(1) << pick);
    perm_unrank = up_stage.perm;
    if (PLACE) begin
      perm_unrank[PLACE_LSB +: prr_pkg::DIGIT_W] = pick;
    end
  end

  always_comb begin
    stage_nxt        = up_stage;
    stage_nxt.digits = up_stage.digits >> prr_pkg::DIGIT_W;
    unique case (up_stage.opcode)
      prr_pkg::OP_RANK: begin
        stage_nxt.err  = up_stage.err | bad;
        stage_nxt.used = used_rank[prr_pkg::MAX_ELEMS-1:0];
        stage_nxt.num  = up_stage.num + rank_prod[prr_pkg::RANK_W-1:0];
      end
      prr_pkg::OP_UNRANK: begin
        stage_nxt.used = used_unrank[prr_pkg::MAX_ELEMS-1:0];
        stage_nxt.num  = up_stage.num - sub_val;
        stage_nxt.perm = perm_unrank;
      end
      default: begin
        stage_nxt = up_stage;
      end
    endcase
  end

  assign up_ready   = !valid_r || down_ready;
  assign down_valid = valid_r;
  assign down_stage = stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_valid && up_ready) begin
      valid_r <= 1'b1;
    end else if (down_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/permutation_rank_unrank.sv
// Top level: permutation <-> lexicographic rank converter (Lehmer code).
// Depends on prr_pkg and prr_cell.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+--------------------------
//   in_     | input     | in_valid / in_ready | in_data   (in_item_t)
//   out_    | output    | out_valid/out_ready | out_data  (out_item_t)
//
// Throughput: one beat per cycle while out_ready is high. Each cell
// handles one digit position and owns one stage register.
// The last cell's register is the output register.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// Stalls: each stage takes a new beat when it is empty or its neighbor
// takes its current one, so bubbles collapse and in_ready stays high
// while any stage is free, even with a result waiting on out_ready.
`timescale 1ns / 1ps
`default_nettype none

module permutation_rank_unrank #(
  parameter int NUM_ELEMENTS = prr_pkg::NUM_ELEMENTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire prr_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output prr_pkg::out_item_t     out_data
);

  localparam logic [prr_pkg::FACT_W-1:0] FACT_N = prr_pkg::fact(NUM_ELEMENTS);
  localparam logic [prr_pkg::FACT_W-1:0] RANK_LIM =
    prr_pkg::FACT_W'(64'd1 << prr_pkg::RANK_W);

  logic [NUM_ELEMENTS:0]  vld;
  logic [NUM_ELEMENTS:0]  rdy;
  prr_pkg::stage_t        stg [0:NUM_ELEMENTS];
  prr_pkg::stage_t        stage_in;
  prr_pkg::stage_t        last;
  logic                   rank_big;

  // Entry: a rank of N! or more is flagged here; with N of 10 and up, N!
  // exceeds the rank field and the check never fires.
  always_comb begin
    rank_big = (FACT_N < RANK_LIM) &&
               (prr_pkg::FACT_W'(in_data.rank_in) >= FACT_N);
    stage_in        = '0;
    stage_in.opcode = in_data.opcode;
    stage_in.digits = in_data.perm_in;
    if (in_data.opcode == prr_pkg::OP_UNRANK) begin
      stage_in.num = in_data.rank_in;
      stage_in.err = rank_big;
    end
  end

  assign stg[0]            = stage_in;
  assign vld[0]            = in_valid;
  assign in_ready          = rdy[0];
  assign rdy[NUM_ELEMENTS] = out_ready;

  // One cell per digit position, position 0 first
  for (genvar p = 0; p < NUM_ELEMENTS; p++) begin : g_cell
    prr_cell #(
      .NUM_ELEMENTS (NUM_ELEMENTS),
      .POS          (p)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (vld[p]),
      .up_ready   (rdy[p]),
      .up_stage   (stg[p]),
      .down_valid (vld[p+1]),
      .down_ready (rdy[p+1]),
      .down_stage (stg[p+1])
    );
  end

  // Result formatting: only the field of the chosen direction, zero on error
  always_comb begin
    last              = stg[NUM_ELEMENTS];
    out_data          = '0;
    out_data.error    = last.err;
    if (!last.err && (last.opcode == prr_pkg::OP_RANK)) begin
      out_data.rank_out = last.num;
    end
    if (!last.err && (last.opcode == prr_pkg::OP_UNRANK)) begin
      out_data.perm_out = last.perm;
    end
  end

  assign out_valid = vld[NUM_ELEMENTS];

endmodule

`default_nettype wire
